[hw/rtl/ntpod_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpod_pkg
// Shared types, constants and time arithmetic helpers for the NTP offset and
// delay pipeline. Times are sign-magnitude seconds plus microseconds.
// ----------------------------------------------------------------------------
package ntpod_pkg;

  localparam int          US_W        = 20;
  localparam int          SECS_W      = 32;
  localparam int          FRAC_W      = 32;
  localparam logic [19:0] US_PER_SEC  = 20'd1000000;
  localparam logic [19:0] HALF_SEC_US = 20'd500000;
  localparam logic [19:0] US_MAX      = 20'd999999;

  // Sign-magnitude time value
  typedef struct packed {
    logic [SECS_W-1:0] s;
    logic [US_W-1:0]   us;
    logic              neg;
  } stime_t;

  // Result of the combine stage, still waiting for the borrow fix-up
  typedef struct packed {
    stime_t r;
    logic   fix;   // came from a magnitude subtract, needs the fix-up
    logic   inv;   // flip the sign after the fix-up
  } pend_t;

  // First half of a - b on two magnitudes: borrow, seconds compare.
  function automatic stime_t msub_raw(stime_t a, stime_t b);
    stime_t      r;
    logic        borrow;
    logic [31:0] bs;
    borrow = (b.us > a.us);
    r.us   = borrow ? (a.us - b.us + US_PER_SEC) : (a.us - b.us);
    bs     = b.s + {31'd0, borrow};
    r.neg  = (bs > a.s);
    r.s    = r.neg ? (bs - a.s) : (a.s - bs);
    return r;
  endfunction

  // Second half of a - b: a negative result with microseconds left over
  // borrows one second back.
  function automatic stime_t msub_fix(stime_t r);
    stime_t o;
    o = r;
    if (r.neg && (r.us != '0)) begin
      o.us = US_PER_SEC - r.us;
      o.s  = r.s - 32'd1;
    end
    return o;
  endfunction

  // a + b on two magnitudes with microsecond carry
  function automatic stime_t mag_add(stime_t a, stime_t b);
    stime_t      r;
    logic [20:0] sum;
    logic [20:0] dif;
    sum   = {1'b0, a.us} + {1'b0, b.us};
    dif   = sum - {1'b0, US_PER_SEC};
    r.neg = 1'b0;
    if (sum >= {1'b0, US_PER_SEC}) begin
      r.us = dif[19:0];
      r.s  = a.s + b.s + 32'd1;
    end else begin
      r.us = sum[19:0];
      r.s  = a.s + b.s;
    end
    return r;
  endfunction

  // Halve a value; an odd second moves down as half a second
  function automatic stime_t half(stime_t a);
    stime_t r;
    r     = a;
    r.us  = a.s[0] ? (HALF_SEC_US + (a.us >> 1)) : (a.us >> 1);
    r.s   = a.s >> 1;
    return r;
  endfunction

endpackage

[hw/rtl/ntpod_conv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpod_conv
// Stage 1: NTP binary fractions to microseconds, t3 microsecond clamp.
// ----------------------------------------------------------------------------
module ntpod_conv
  import ntpod_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       t0_secs,
  input  logic [31:0]       t0_frac,
  input  logic [31:0]       t1_secs,
  input  logic [31:0]       t1_frac,
  input  logic [31:0]       t2_secs,
  input  logic [31:0]       t2_frac,
  input  logic [31:0]       t3_secs,
  input  logic [19:0]       t3_micros,
  output logic              out_valid,
  input  logic              out_ready,
  output stime_t            t0,
  output stime_t            t1,
  output stime_t            t2,
  output stime_t            t3
);

  logic   valid_r;
  stime_t t0_r, t1_r, t2_r, t3_r;
  stime_t t0_nxt, t1_nxt, t2_nxt, t3_nxt;

  // (frac * 1e6) >> 32, truncated
  function automatic logic [19:0] frac_to_us(logic [31:0] frac);
    logic [51:0] prod;
    prod = {20'd0, frac} * {32'd0, US_PER_SEC};
    return prod[51:32];
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    t0_nxt = '{s: t0_secs, us: frac_to_us(t0_frac), neg: 1'b0};
    t1_nxt = '{s: t1_secs, us: frac_to_us(t1_frac), neg: 1'b0};
    t2_nxt = '{s: t2_secs, us: frac_to_us(t2_frac), neg: 1'b0};
    t3_nxt = '{s: t3_secs, us: (t3_micros > US_MAX) ? US_MAX : t3_micros, neg: 1'b0};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
    end
  end

  assign out_valid = valid_r;
  assign t0 = t0_r;
  assign t1 = t1_r;
  assign t2 = t2_r;
  assign t3 = t3_r;

endmodule

[hw/rtl/ntpod_diff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpod_diff
// Stages 2 and 3: the four timestamp differences, then borrow fix-up and
// halving of the two offset terms.
// ----------------------------------------------------------------------------
module ntpod_diff
  import ntpod_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  stime_t t0,
  input  stime_t t1,
  input  stime_t t2,
  input  stime_t t3,
  output logic   out_valid,
  input  logic   out_ready,
  output stime_t off_a,
  output stime_t off_b,
  output stime_t dly_a,
  output stime_t dly_b
);

  logic   s2_valid_r, s3_valid_r;
  logic   s2_ready, s3_ready;
  stime_t d10_r, d23_r, d30_r, d21_r;
  stime_t d10_nxt, d23_nxt, d30_nxt, d21_nxt;
  stime_t off_a_r, off_b_r, dly_a_r, dly_b_r;
  stime_t off_a_nxt, off_b_nxt, dly_a_nxt, dly_b_nxt;

  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = s2_ready;

  // stage 2: raw magnitude differences
  always_comb begin
    d10_nxt = msub_raw(t1, t0);
    d23_nxt = msub_raw(t2, t3);
    d30_nxt = msub_raw(t3, t0);
    d21_nxt = msub_raw(t2, t1);
  end

  // stage 3: fix-up, offset terms halved
  always_comb begin
    off_a_nxt = half(msub_fix(d10_r));
    off_b_nxt = half(msub_fix(d23_r));
    dly_a_nxt = msub_fix(d30_r);
    dly_b_nxt = msub_fix(d21_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= in_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s2_ready && in_valid) begin
      d10_r <= d10_nxt;
      d23_r <= d23_nxt;
      d30_r <= d30_nxt;
      d21_r <= d21_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      off_a_r <= off_a_nxt;
      off_b_r <= off_b_nxt;
      dly_a_r <= dly_a_nxt;
      dly_b_r <= dly_b_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign off_a = off_a_r;
  assign off_b = off_b_r;
  assign dly_a = dly_a_r;
  assign dly_b = dly_b_r;

endmodule

[hw/rtl/ntpod_comb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpod_comb
// Stages 4 and 5: signed add for the offset, signed subtract for the delay,
// then fix-up, sign and zero cleanup into the output register.
// ----------------------------------------------------------------------------
module ntpod_comb
  import ntpod_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  stime_t off_a,
  input  stime_t off_b,
  input  stime_t dly_a,
  input  stime_t dly_b,
  output logic   out_valid,
  input  logic   out_ready,
  output stime_t off,
  output stime_t dly
);

  logic   s4_valid_r, s5_valid_r;
  logic   s4_ready, s5_ready;
  pend_t  off_p_r, dly_p_r;
  pend_t  off_p_nxt, dly_p_nxt;
  stime_t off_r, dly_r;
  stime_t off_nxt, dly_nxt;

  assign s5_ready = !s5_valid_r || out_ready;
  assign s4_ready = !s4_valid_r || s5_ready;
  assign in_ready = s4_ready;

  // stage 4: offset = a + b
  always_comb begin
    off_p_nxt.inv = 1'b0;
    if (off_a.neg != off_b.neg) begin
      off_p_nxt.fix = 1'b1;
      off_p_nxt.r   = off_a.neg ? msub_raw(off_b, off_a) : msub_raw(off_a, off_b);
    end else begin
      off_p_nxt.fix   = 1'b0;
      off_p_nxt.r     = mag_add(off_a, off_b);
      off_p_nxt.r.neg = off_a.neg;
    end
  end

  // stage 4: delay = a - b
  always_comb begin
    dly_p_nxt.inv = 1'b0;
    if (!dly_a.neg && dly_b.neg) begin
      dly_p_nxt.fix = 1'b0;
      dly_p_nxt.r   = mag_add(dly_a, dly_b);
    end else if (dly_a.neg && dly_b.neg) begin
      dly_p_nxt.fix = 1'b1;
      dly_p_nxt.inv = 1'b1;
      dly_p_nxt.r   = msub_raw(dly_a, dly_b);
    end else if (dly_a.neg) begin
      dly_p_nxt.fix   = 1'b0;
      dly_p_nxt.r     = mag_add(dly_a, dly_b);
      dly_p_nxt.r.neg = 1'b1;
    end else begin
      dly_p_nxt.fix = 1'b1;
      dly_p_nxt.r   = msub_raw(dly_a, dly_b);
    end
  end

  // stage 5: fix-up, sign flip, no negative zero
  always_comb begin
    off_nxt     = off_p_r.fix ? msub_fix(off_p_r.r) : off_p_r.r;
    off_nxt.neg = off_nxt.neg ^ off_p_r.inv;
    if ((off_nxt.s == '0) && (off_nxt.us == '0)) begin
      off_nxt.neg = 1'b0;
    end
    dly_nxt     = dly_p_r.fix ? msub_fix(dly_p_r.r) : dly_p_r.r;
    dly_nxt.neg = dly_nxt.neg ^ dly_p_r.inv;
    if ((dly_nxt.s == '0) && (dly_nxt.us == '0)) begin
      dly_nxt.neg = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid_r <= in_valid;
      end
      if (s5_ready) begin
        s5_valid_r <= s4_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s4_ready && in_valid) begin
      off_p_r <= off_p_nxt;
      dly_p_r <= dly_p_nxt;
    end
    if (s5_ready && s4_valid_r) begin
      off_r <= off_nxt;
      dly_r <= dly_nxt;
    end
  end

  assign out_valid = s5_valid_r;
  assign off = off_r;
  assign dly = dly_r;

endmodule

[hw/rtl/ntp_offset_and_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_offset_and_delay
// Clock offset and round trip delay from the four timestamps of one exchange.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with t0..t2 as 32.32 NTP timestamps
//   and t3 as seconds plus microseconds. An item is taken on a clock edge
//   with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with offset and delay, each as a
//   magnitude in seconds plus microseconds and a negative flag.
//   Five register stages: fraction multiply, raw differences, fix-up and
//   halving, signed combine, final fix-up. out_valid is the valid bit of
//   the final fix-up stage; a result is taken on an edge with out_stall low.
//   Throughput is one item per cycle when out_stall is low; each stage
//   holds one item and moves on when the stage after it is empty or moving.
//   When the receiver stalls, the output register holds its item and the
//   stages behind it keep filling; in_stall rises only once all five
//   stages hold items. Nothing is dropped or repeated.
//   Synchronous reset (rst_n low) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module ntp_offset_and_delay
  import ntpod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_t0_secs,
  input  logic [31:0] in_t0_frac,
  input  logic [31:0] in_t1_secs,
  input  logic [31:0] in_t1_frac,
  input  logic [31:0] in_t2_secs,
  input  logic [31:0] in_t2_frac,
  input  logic [31:0] in_t3_secs,
  input  logic [19:0] in_t3_micros,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_offset_secs,
  output logic [19:0] out_offset_micros,
  output logic        out_offset_negative,
  output logic [31:0] out_delay_secs,
  output logic [19:0] out_delay_micros,
  output logic        out_delay_negative
);

  logic   conv_ready, conv_valid;
  logic   diff_ready, diff_valid;
  logic   comb_ready;
  stime_t t0, t1, t2, t3;
  stime_t off_a, off_b, dly_a, dly_b;
  stime_t off, dly;

  assign in_stall = !conv_ready;

  ntpod_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (conv_ready),
    .t0_secs   (in_t0_secs),
    .t0_frac   (in_t0_frac),
    .t1_secs   (in_t1_secs),
    .t1_frac   (in_t1_frac),
    .t2_secs   (in_t2_secs),
    .t2_frac   (in_t2_frac),
    .t3_secs   (in_t3_secs),
    .t3_micros (in_t3_micros),
    .out_valid (conv_valid),
    .out_ready (diff_ready),
    .t0        (t0),
    .t1        (t1),
    .t2        (t2),
    .t3        (t3)
  );

  ntpod_diff u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (conv_valid),
    .in_ready  (diff_ready),
    .t0        (t0),
    .t1        (t1),
    .t2        (t2),
    .t3        (t3),
    .out_valid (diff_valid),
    .out_ready (comb_ready),
    .off_a     (off_a),
    .off_b     (off_b),
    .dly_a     (dly_a),
    .dly_b     (dly_b)
  );

  ntpod_comb u_comb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (diff_valid),
    .in_ready  (comb_ready),
    .off_a     (off_a),
    .off_b     (off_b),
    .dly_a     (dly_a),
    .dly_b     (dly_b),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .off       (off),
    .dly       (dly)
  );

  assign out_offset_secs     = off.s;
  assign out_offset_micros   = off.us;
  assign out_offset_negative = off.neg;
  assign out_delay_secs      = dly.s;
  assign out_delay_micros    = dly.us;
  assign out_delay_negative  = dly.neg;

  // input backs up only when the whole pipeline is full and stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");

  // microseconds stay normalized
  a_us_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_offset_micros < US_PER_SEC) && (out_delay_micros < US_PER_SEC)))
    else $error("microseconds out of range");

  // no negative zero on either result
  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_offset_negative && (out_offset_secs == '0) &&
                     (out_offset_micros == '0)) ||
                    (out_delay_negative && (out_delay_secs == '0) &&
                     (out_delay_micros == '0))))
    else $error("negative zero result");

endmodule

[dv/tb_ntp_offset_and_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntp_offset_and_delay
// Self-checking bench for the NTP offset and round trip delay pipeline.
// Timestamp sets go in through the valid/stall input channel. Each accepted
// item is run through a local bit-exact calculation of offset and delay, and
// the expected result is queued. Every result taken from the output channel is
// compared field by field with the oldest queued one. Coverage comes from
// directed extremes and corner cases, realistic exchanges near and across the
// seconds wrap, fully random sets, and a long receiver hold-off that fills the
// pipeline. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ntp_offset_and_delay;
  import ntpod_pkg::*;

  localparam int          STALL_LIMIT = 4000;  // cycles with no item moving
  localparam int          HOLD_CYCLES = 64;
  localparam int          DRAIN_WAIT  = 8;
  localparam bit [20:0]   MICROS_SEC  = 21'd1000000;
  localparam bit [20:0]   MICROS_HALF = 21'd500000;
  localparam bit [19:0]   MICROS_TOP  = 20'd999999;

  // Fraction codes with known microsecond values
  localparam bit [31:0]   FRAC_1US    = 32'd4295;        // 1 us
  localparam bit [31:0]   FRAC_HALF   = 32'h8000_0000;   // 500000 us
  localparam bit [31:0]   FRAC_0P8    = 32'hCCCC_CCCD;   // 800000 us
  localparam bit [31:0]   ALL_ONES    = 32'hFFFF_FFFF;

  // Working time value: microseconds one bit wider to hold a carry
  typedef struct packed {
    bit [31:0] s;
    bit [20:0] us;
    bit        neg;
  } span_t;

  typedef struct packed {
    bit [31:0] off_s;
    bit [19:0] off_us;
    bit        off_neg;
    bit [31:0] dly_s;
    bit [19:0] dly_us;
    bit        dly_neg;
  } od_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_t0_secs;
  logic [31:0] in_t0_frac;
  logic [31:0] in_t1_secs;
  logic [31:0] in_t1_frac;
  logic [31:0] in_t2_secs;
  logic [31:0] in_t2_frac;
  logic [31:0] in_t3_secs;
  logic [19:0] in_t3_micros;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_offset_secs;
  logic [19:0] out_offset_micros;
  logic        out_offset_negative;
  logic [31:0] out_delay_secs;
  logic [19:0] out_delay_micros;
  logic        out_delay_negative;

  od_result_t  offset_delay_q[$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          input_stall_cycles;
  bit          tx_jitter;
  bit          rx_jitter;
  bit          hold_req;

  ntp_offset_and_delay dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Offset / delay calculation
  // --------------------------------------------------------------------------
  function automatic bit [20:0] frac_micros(bit [31:0] frac);
    bit [63:0] prod;
    prod = {32'd0, frac} * 64'd1000000;
    return 21'(prod >> 32);
  endfunction

  // a - b on two magnitudes, borrow between the parts
  function automatic span_t span_diff(span_t a, span_t b);
    span_t     r;
    bit        borrow;
    bit [31:0] bsec;
    borrow = (b.us > a.us);
    r.us   = borrow ? (a.us + MICROS_SEC - b.us) : (a.us - b.us);
    bsec   = b.s + {31'd0, borrow};
    r.neg  = (bsec > a.s);
    r.s    = r.neg ? (bsec - a.s) : (a.s - bsec);
    if (r.neg && r.us != '0) begin
      r.us = MICROS_SEC - r.us;
      r.s  = r.s - 32'd1;
    end
    return r;
  endfunction

  function automatic span_t span_sum(span_t a, span_t b);
    span_t r;
    r.neg = 1'b0;
    r.us  = a.us + b.us;
    if (r.us >= MICROS_SEC) begin
      r.us = r.us - MICROS_SEC;
      r.s  = a.s + b.s + 32'd1;
    end else begin
      r.s  = a.s + b.s;
    end
    return r;
  endfunction

  // odd second drops into the microseconds as half a second
  function automatic span_t halve(span_t a);
    span_t r;
    r     = a;
    r.us  = a.s[0] ? (MICROS_HALF + (a.us >> 1)) : (a.us >> 1);
    r.s   = a.s >> 1;
    return r;
  endfunction

  function automatic span_t signed_sum(span_t a, span_t b);
    span_t r;
    if (a.neg && !b.neg) begin
      r = span_diff(b, a);
    end else if (!a.neg && b.neg) begin
      r = span_diff(a, b);
    end else begin
      r     = span_sum(a, b);
      r.neg = a.neg;
    end
    return r;
  endfunction

  function automatic span_t signed_diff(span_t a, span_t b);
    span_t r;
    if (!a.neg && b.neg) begin
      r = span_sum(a, b);
    end else if (a.neg && b.neg) begin
      r     = span_diff(a, b);
      r.neg = !r.neg;
    end else if (a.neg && !b.neg) begin
      r     = span_sum(a, b);
      r.neg = 1'b1;
    end else begin
      r = span_diff(a, b);
    end
    return r;
  endfunction

  function automatic od_result_t calc_offset_delay(
    bit [31:0] t0s, bit [31:0] t0f, bit [31:0] t1s, bit [31:0] t1f,
    bit [31:0] t2s, bit [31:0] t2f, bit [31:0] t3s, bit [19:0] t3u);
    span_t      t0, t1, t2, t3, off, dly;
    bit [19:0]  t3c;
    od_result_t r;
    t3c = (t3u > MICROS_TOP) ? MICROS_TOP : t3u;
    t0  = '{s: t0s, us: frac_micros(t0f), neg: 1'b0};
    t1  = '{s: t1s, us: frac_micros(t1f), neg: 1'b0};
    t2  = '{s: t2s, us: frac_micros(t2f), neg: 1'b0};
    t3  = '{s: t3s, us: {1'b0, t3c}, neg: 1'b0};
    off = signed_sum(halve(span_diff(t1, t0)), halve(span_diff(t2, t3)));
    dly = signed_diff(span_diff(t3, t0), span_diff(t2, t1));
    // no negative zero
    if (off.s == '0 && off.us == '0) off.neg = 1'b0;
    if (dly.s == '0 && dly.us == '0) dly.neg = 1'b0;
    r.off_s   = off.s;
    r.off_us  = off.us[19:0];
    r.off_neg = off.neg;
    r.dly_s   = dly.s;
    r.dly_us  = dly.us[19:0];
    r.dly_neg = dly.neg;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle lengths: mostly short, a few long
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Send one timestamp set and queue its expected result on acceptance
  // --------------------------------------------------------------------------
  task automatic send_stamps(input bit [31:0] t0s, input bit [31:0] t0f,
                             input bit [31:0] t1s, input bit [31:0] t1f,
                             input bit [31:0] t2s, input bit [31:0] t2f,
                             input bit [31:0] t3s, input bit [19:0] t3u);
    if (tx_jitter && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_t0_secs   <= t0s;
    in_t0_frac   <= t0f;
    in_t1_secs   <= t1s;
    in_t1_frac   <= t1f;
    in_t2_secs   <= t2s;
    in_t2_frac   <= t2f;
    in_t3_secs   <= t3s;
    in_t3_micros <= t3u;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    offset_delay_q.push_back(calc_offset_delay(t0s, t0f, t1s, t1f, t2s, t2f, t3s, t3u));
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_field_extremes();
    send_stamps('0, '0, '0, '0, '0, '0, '0, '0);
    send_stamps(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                ALL_ONES, ALL_ONES, ALL_ONES, 20'hFFFFF);
    send_stamps(ALL_ONES, ALL_ONES, '0, '0, '0, '0, '0, '0);
    send_stamps('0, '0, ALL_ONES, ALL_ONES, '0, '0, '0, '0);
    send_stamps('0, '0, '0, '0, ALL_ONES, ALL_ONES, '0, '0);
    send_stamps('0, '0, '0, '0, '0, '0, ALL_ONES, MICROS_TOP);
    send_stamps(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 20'hAAAAA);
    send_stamps(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 20'h55555);
  endtask

  task automatic test_special_cases();
    // microseconds just past the top of range and at the top
    send_stamps(32'd50, 0, 32'd50, 0, 32'd51, 0, 32'd51, 20'd1000000);
    send_stamps(32'd50, 0, 32'd50, 0, 32'd51, 0, 32'd51, MICROS_TOP);
    // delay legs both negative and equal: would give negative zero
    send_stamps(32'd10, 0, 32'd10, 0, 32'd5, 0, 32'd5, 0);
    // offset halves both round to a negative zero
    send_stamps(32'd100, FRAC_1US, 32'd100, 0, 32'd200, 0, 32'd200, 20'd1);
    // odd seconds halved
    send_stamps(32'd0, 0, 32'd3, 0, 32'd3, FRAC_HALF, 32'd1, 20'd0);
    // seconds wrap across the top
    send_stamps(32'hFFFF_FFFE, FRAC_HALF, 32'd1, 0, 32'd2, FRAC_1US, 32'd1, 20'd7);
    // negative delay: local receive before client send
    send_stamps(32'd1000, FRAC_HALF, 32'd1000, 0, 32'd1001, 0, 32'd998, 20'd0);
    // microsecond borrow
    send_stamps(32'd7, ALL_ONES, 32'd8, 0, 32'd8, FRAC_1US, 32'd9, 20'd0);
    // microsecond carry when the halves add up
    send_stamps(32'd0, 0, 32'd1, FRAC_0P8, 32'd1, FRAC_0P8, 32'd0, 20'd0);
    // offset negative with a negative delay
    send_stamps(32'd500, FRAC_HALF, 32'd300, 0, 32'd300, FRAC_0P8, 32'd501, 20'd250000);
  endtask

  task automatic test_random_exchanges(input int count);
    bit [31:0] base, skew, t1s, t2s, t3s;
    bit [19:0] t3u;
    for (int k = 0; k < count; k++) begin
      // first quarter back to back, then idling on both sides
      tx_jitter = (k >= count / 4);
      rx_jitter = tx_jitter;
      case ($urandom_range(0, 3))
        0:       base = $urandom;
        1:       base = ALL_ONES - $urandom_range(0, 8);
        2:       base = $urandom_range(0, 8);
        default: base = 32'hE000_0000 + $urandom_range(0, 1 << 20);
      endcase
      skew = ($urandom_range(0, 9) == 0) ? $urandom : ($urandom_range(0, 8) - 4);
      t1s  = base + skew + $urandom_range(0, 1);
      t2s  = t1s + $urandom_range(0, 1);
      t3s  = ($urandom_range(0, 19) == 0) ? base - 1 : base + $urandom_range(0, 2);
      t3u  = ($urandom_range(0, 19) == 0) ? 20'($urandom_range(1000000, 20'hFFFFF))
                                          : 20'($urandom_range(0, 999999));
      send_stamps(base, $urandom, t1s, $urandom, t2s, $urandom, t3s, t3u);
    end
  endtask

  task automatic test_random_raw(input int count);
    for (int k = 0; k < count; k++) begin
      // sender idles in the first half, receiver in the second
      tx_jitter = (k < count / 2);
      rx_jitter = !tx_jitter;
      send_stamps($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 20'($urandom_range(0, 20'hFFFFF)));
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_back_pressure(input int count);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    hold_req  = 1'b1;
    for (int k = 0; k < count; k++) begin
      send_stamps($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 20'($urandom_range(0, 999999)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest expected item
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input bit [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    od_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (offset_delay_q.size() == 0) begin
        errors++;
        $error("result item with no expected item pending");
      end else begin
        want = offset_delay_q.pop_front();
        results_seen++;
        check_field("offset_secs",     want.off_s,        out_offset_secs);
        check_field("offset_micros",   32'(want.off_us),  32'(out_offset_micros));
        check_field("offset_negative", 32'(want.off_neg), 32'(out_offset_negative));
        check_field("delay_secs",      want.dly_s,        out_delay_secs);
        check_field("delay_micros",    32'(want.dly_us),  32'(out_delay_micros));
        check_field("delay_negative",  32'(want.dly_neg), 32'(out_delay_negative));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no item moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d results still pending", offset_delay_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    errors             = 0;
    items_sent         = 0;
    results_seen       = 0;
    input_stall_cycles = 0;
    tx_jitter          = 1'b0;
    rx_jitter          = 1'b0;
    hold_req           = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_t0_secs   <= '0;
    in_t0_frac   <= '0;
    in_t1_secs   <= '0;
    in_t1_frac   <= '0;
    in_t2_secs   <= '0;
    in_t2_frac   <= '0;
    in_t3_secs   <= '0;
    in_t3_micros <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_special_cases();
    test_random_exchanges(600);
    test_random_raw(300);
    test_back_pressure(50);

    in_valid <= 1'b0;
    while (offset_delay_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d timestamp sets (extremes, corner cases, exchanges, raw, hold-off);",
             items_sent);
    $display("checked %0d results, input held off for %0d cycles.",
             results_seen, input_stall_cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ntpod_pkg.sv
hw/rtl/ntpod_conv.sv
hw/rtl/ntpod_diff.sv
hw/rtl/ntpod_comb.sv
hw/rtl/ntp_offset_and_delay.sv
dv/tb_ntp_offset_and_delay.sv
